// ----- hdl/pli_pkg.sv -----
// Shared types and constants for the piecewise linear table interpolator.
`default_nettype none

package pli_pkg;

  // Default table geometry
  localparam int SPECIES_DEF = 32;
  localparam int BINS_DEF    = 64;

  // Field widths fixed by the interface
  localparam int SPECIES_W = 5;
  localparam int ENERGY_W  = 32;
  localparam int FLUX_W    = 32;
  localparam int SEGMENT_W = 6;

  // Action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;
  localparam logic [1:0] ST_ZERO_W  = 2'd3;

  // Divider: one quotient bit per cycle over a 64-bit dividend
  localparam int DIV_STEPS = 64;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // Commands from the sequencer to the table store
  typedef struct packed {
    logic                 clear;
    logic                 append;
    logic [SPECIES_W-1:0] species;
  } tbl_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/pli_table.sv -----
// Breakpoint memories and per-species entry counts.
`default_nettype none

module pli_table #(
  parameter int SPECIES = pli_pkg::SPECIES_DEF,
  parameter int BINS    = pli_pkg::BINS_DEF,
  localparam int AW     = $clog2(SPECIES * BINS),
  localparam int CW     = $clog2(BINS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  pli_pkg::tbl_cmd_t cmd,
  input  logic [31:0]      wr_energy,
  input  logic [31:0]      wr_flux,
  input  logic [AW-1:0]    rd_addr,
  output logic [31:0]      rd_energy,
  output logic [31:0]      rd_flux,
  output logic [CW-1:0]    count
);
  import pli_pkg::*;

  localparam int DEPTH = SPECIES * BINS;
  localparam int SIW   = (SPECIES > 1) ? $clog2(SPECIES) : 1;

  logic [31:0]   mem_energy [DEPTH];
  logic [31:0]   mem_flux   [DEPTH];
  logic [CW-1:0] cnt        [SPECIES];

  logic           sp_valid;
  logic [SIW-1:0] sp_idx;
  logic [AW-1:0]  wr_addr;

  assign sp_valid = 32'(cmd.species) < SPECIES;
  assign sp_idx   = SIW'(cmd.species);
  assign count    = sp_valid ? cnt[sp_idx] : '0;
  assign wr_addr  = AW'(AW'(sp_idx) * AW'(BINS)) + AW'(count);

  // Clear every count at once, or advance the selected one on append
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < SPECIES; i++) begin
        cnt[i] <= '0;
      end
    end else if (cmd.append) begin
      cnt[sp_idx] <= cnt[sp_idx] + CW'(1);
    end
  end

  // Breakpoint memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem_energy[wr_addr] <= wr_energy;
      mem_flux[wr_addr]   <= wr_flux;
    end
    rd_energy <= mem_energy[rd_addr];
    rd_flux   <= mem_flux[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hdl/pli_divider.sv -----
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
`default_nettype none

module pli_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import pli_pkg::*;

  logic              active;
  logic [DIV_CW-1:0] cnt;
  logic [32:0]       rem;
  logic [31:0]       dvs;
  logic [32:0]       rem_sh;
  logic              take;

  assign rem_sh = {rem[31:0], quotient[63]};
  assign take   = rem_sh >= {1'b0, dvs};

  // Control: run for a fixed number of steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + DIV_CW'(1);
        if (cnt == DIV_CW'(DIV_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift a dividend bit into the remainder, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (active) begin
      rem      <= take ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quotient <= {quotient[62:0], take};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/piecewise_linear_table_interpolator_top.sv -----
// Top level: command sequencer for the piecewise linear table interpolator.
`default_nettype none

// A command is taken when start is high and busy is low; its single result
// appears on flux_out, segment and status for one cycle while done is high,
// and the receiver cannot stall it. Clear, append, unused action codes and
// queries with fewer than two entries or an invalid species finish in S_EXEC.
// A query scans the species table through one registered memory read port,
// visiting each breakpoint in S_RADDR and S_RDATA, then passes through
// S_DIFF (zero-width check), S_MUL (product) and S_DSTART (divider launch),
// and waits in S_DIV for the bit-serial divider, picking up its quotient
// there; it reads at most BINS breakpoints. A zero-width segment ends
// right after the scan, in S_DIFF. Busy stays high for the whole command.
module piecewise_linear_table_interpolator_top #(
  parameter int SPECIES = pli_pkg::SPECIES_DEF,
  parameter int BINS    = pli_pkg::BINS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       action,
  input  logic [pli_pkg::SPECIES_W-1:0]    species,
  input  logic [pli_pkg::ENERGY_W-1:0]     energy,
  input  logic [pli_pkg::FLUX_W-1:0]       flux_in,
  output logic                             done,
  output logic signed [pli_pkg::FLUX_W-1:0] flux_out,
  output logic [pli_pkg::SEGMENT_W-1:0]    segment,
  output logic [1:0]                       status
);
  import pli_pkg::*;

  localparam int AW = $clog2(SPECIES * BINS);
  localparam int CW = $clog2(BINS + 1);
  localparam int IW = $clog2(BINS);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_RADDR  = 8'b0000_0100,
    S_RDATA  = 8'b0000_1000,
    S_DIFF   = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_DSTART = 8'b0100_0000,
    S_DIV    = 8'b1000_0000
  } state_t;

  state_t state;

  // Latched command beat
  logic [1:0]           act;
  logic [SPECIES_W-1:0] sp;
  logic [31:0]          e_q;
  logic [31:0]          f_in_q;
  logic [AW-1:0]        base;

  // Scan registers
  logic [CW-1:0] n;
  logic [IW-1:0] ptr;
  logic [31:0]   prev_e, prev_f;
  logic [31:0]   ea, eb, fa, fb;

  // Chosen segment and arithmetic
  logic [IW-1:0] id;
  logic [31:0]   e0, e1, f0, f1;
  logic [31:0]   mdf, mde, mw;
  logic          neg;
  logic [63:0]   prod;

  // Table and divider links
  tbl_cmd_t      cmd;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_energy, rd_flux;
  logic [CW-1:0] count;
  logic          sp_valid;
  logic          full;
  logic          div_done;
  logic [63:0]   quotient;

  logic          hit;
  logic          last;
  logic [34:0]   r_sum;
  logic [31:0]   result;

  assign busy     = state != S_IDLE;
  assign sp_valid = 32'(sp) < SPECIES;
  assign full     = count >= CW'(BINS);

  assign cmd.clear   = (state == S_EXEC) && (act == ACT_CLEAR);
  assign cmd.append  = (state == S_EXEC) && (act == ACT_APPEND) && sp_valid && !full;
  assign cmd.species = sp;
  assign rd_addr     = base + AW'(ptr);

  assign hit  = (e_q >= prev_e) && (e_q <= rd_energy);
  assign last = CW'(ptr) == n - CW'(1);

  pli_table #(
    .SPECIES (SPECIES),
    .BINS    (BINS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_energy (e_q),
    .wr_flux   (f_in_q),
    .rd_addr   (rd_addr),
    .rd_energy (rd_energy),
    .rd_flux   (rd_flux),
    .count     (count)
  );

  pli_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DSTART),
    .dividend (prod),
    .divisor  (mw),
    .done     (div_done),
    .quotient (quotient)
  );

  // Apply the sign, add f1 and saturate to the signed 32-bit range
  always_comb begin
    r_sum = neg ? ({3'b000, f1} - {2'b00, quotient[32:0]})
                : ({3'b000, f1} + {2'b00, quotient[32:0]});
    if (|quotient[63:33]) begin
      result = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (!r_sum[34] && (|r_sum[33:31])) begin
      result = 32'h7FFF_FFFF;
    end else if (r_sum[34] && !(&r_sum[33:31])) begin
      result = 32'h8000_0000;
    end else begin
      result = r_sum[31:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act    <= action;
            sp     <= species;
            e_q    <= energy;
            f_in_q <= flux_in;
            base   <= AW'(32'(species) * BINS);
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          flux_out <= '0;
          segment  <= '0;
          status   <= ST_OK;
          unique case (act)
            ACT_CLEAR: begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
            ACT_APPEND: begin
              if (!sp_valid || full) begin
                status <= ST_FULL;
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
            ACT_QUERY: begin
              if (!sp_valid || count < CW'(2)) begin
                status <= ST_SHORT;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                n     <= count;
                ptr   <= '0;
                state <= S_RADDR;
              end
            end
            default: begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end

        // The table registers the read data, so it is valid in S_RDATA
        S_RADDR: begin
          state <= S_RDATA;
        end

        S_RDATA: begin
          if (ptr == '0) begin
            prev_e <= rd_energy;
            prev_f <= rd_flux;
            ea     <= rd_energy;
            fa     <= rd_flux;
            ptr    <= IW'(1);
            state  <= S_RADDR;
          end else begin
            if (ptr == IW'(1)) begin
              eb <= rd_energy;
              fb <= rd_flux;
            end
            if (hit) begin
              e0    <= prev_e;
              f0    <= prev_f;
              e1    <= rd_energy;
              f1    <= rd_flux;
              id    <= ptr - IW'(1);
              state <= S_DIFF;
            end else if (last) begin
              // No segment brackets the energy: extrapolate from the first
              e0    <= ea;
              f0    <= fa;
              e1    <= (ptr == IW'(1)) ? rd_energy : eb;
              f1    <= (ptr == IW'(1)) ? rd_flux : fb;
              id    <= '0;
              state <= S_DIFF;
            end else begin
              prev_e <= rd_energy;
              prev_f <= rd_flux;
              ptr    <= ptr + IW'(1);
              state  <= S_RADDR;
            end
          end
        end

        // Check for a zero-width segment, else form magnitudes and the combined sign
        S_DIFF: begin
          if (e0 == e1) begin
            flux_out <= '0;
            segment  <= SEGMENT_W'(id);
            status   <= ST_ZERO_W;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            mdf   <= (f1 < f0) ? (f0 - f1) : (f1 - f0);
            mde   <= (e_q < e1) ? (e1 - e_q) : (e_q - e1);
            mw    <= (e1 < e0) ? (e0 - e1) : (e1 - e0);
            neg   <= ((f1 < f0) != (e_q < e1)) != (e1 < e0);
            state <= S_MUL;
          end
        end

        S_MUL: begin
          prod  <= 64'(mdf) * 64'(mde);
          state <= S_DSTART;
        end

        S_DSTART: begin
          state <= S_DIV;
        end

        S_DIV: begin
          if (div_done) begin
            flux_out <= result;
            segment  <= SEGMENT_W'(id);
            status   <= ST_OK;
            done     <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
